>>> hdl/serial_mode_frame_receiver_defines.svh
// assertion macros for the checker file
`ifndef SERIAL_MODE_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_MODE_FRAME_RECEIVER_DEFINES_SVH

// clocked check, off while reset is high
`define SMFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define SMFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/smfr_pkg.sv
package smfr_pkg;

   typedef logic [3:0] status_code_type;
   typedef logic [7:0] pins_type;
   typedef logic [3:0] pos_type;

   // one queued status beat
   typedef struct packed {
      status_code_type code;
      pins_type        pins;
   } slot_type;

   // frame bytes
   localparam logic [7:0] HDR_BYTE   = 8'hAA;
   localparam logic [7:0] SYNC_BYTE  = 8'hDD;
   localparam logic [7:0] FIELD_LOW  = 8'h00;
   localparam logic [7:0] FIELD_HIGH = 8'h01;
   localparam logic [7:0] MODE_OFF   = 8'h00;
   localparam logic [7:0] MODE_SYNC  = 8'h01;
   localparam logic [7:0] MODE_SVP   = 8'h02;

   // frame positions
   localparam int      FRAME_LEN   = 10;
   localparam pos_type POS_HEADER  = 4'd0;
   localparam pos_type POS_SYNC    = 4'd1;
   localparam pos_type POS_PAYLOAD = 4'd2;
   localparam pos_type POS_TRAILER = pos_type'(FRAME_LEN - 1);

   // one status slot per setting group
   localparam int NUM_SLOTS   = 6;
   localparam int SLOT_PPS    = 3;
   localparam int SLOT_MODE   = 4;
   localparam int SLOT_SUB    = 5;
   localparam int NUM_PAYLOAD = 7;
   localparam int PL_PPS      = 3;
   localparam int PL_MODE     = 4;
   localparam int PL_SVP      = 5;
   localparam int PL_SYNC     = 6;

   // pin bit positions
   localparam int PIN_HEAD   = 0;
   localparam int PIN_PULSE  = 3;
   localparam int PIN_AUX232 = 4;
   localparam int PIN_AUXRX  = 5;
   localparam int PIN_AUXSD  = 6;
   localparam int PIN_TTL    = 7;
   localparam pins_type PIN_RESET = 8'h78;

   // status codes
   localparam status_code_type ST_HEAD_232   = 4'd0;
   localparam status_code_type ST_HEAD_422   = 4'd1;
   localparam status_code_type ST_PPS_422    = 4'd6;
   localparam status_code_type ST_PPS_TTL    = 4'd7;
   localparam status_code_type ST_MODE_OFF   = 4'd8;
   localparam status_code_type ST_MODE_SYNC  = 4'd9;
   localparam status_code_type ST_MODE_SVP   = 4'd10;
   localparam status_code_type ST_SVP_422    = 4'd11;
   localparam status_code_type ST_SVP_232    = 4'd12;
   localparam status_code_type ST_SYNC_OUT   = 4'd13;
   localparam status_code_type ST_SYNC_IN    = 4'd14;
   localparam status_code_type ST_CODE_MAX   = ST_SYNC_IN;

endpackage

>>> hdl/serial_mode_frame_receiver.sv
// Serial mode frame receiver.
// Input channel (req_): one received byte per beat. Bytes form a 10-byte
// frame: 0xAA, 0xDD, seven payload bytes, trailing 0xDD. A wrong second
// byte drops back to hunting for 0xAA without looking at that byte again.
// Result channel (rsp_): one status beat per applied setting, in field
// order, carrying the status code, the eight pin levels right after that
// setting, and last_status on the final beat of the frame.
// Output: a taken trailer fills the status queue, whose first beat then
// moves to the output register, the rest one per cycle unless stalled. A
// frame yields up to six beats, a bad trailer or no recognized field none.
// Throughput: one byte per cycle. The status queue holds one frame; a
// trailer byte is held off (req_stall) only while beats of the previous
// frame still sit in that queue, which drains at one beat per cycle.
// rsp_stall holds the output register and so backs up the queue.
// Reset (synchronous, active high) returns to header hunting, empties the
// queue and output, and sets heading, motion, gnss and ttl path pins low,
// the other four pins high.
module serial_mode_frame_receiver
   import smfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_status_code,
   output logic       rsp_heading_select,
   output logic       rsp_motion_select,
   output logic       rsp_gnss_select,
   output logic       rsp_pulse_select,
   output logic       rsp_aux_232_485_select,
   output logic       rsp_aux_receive_drive,
   output logic       rsp_aux_shutdown_drive,
   output logic       rsp_ttl_path_select,
   output logic       rsp_last_status
);

   pos_type                pos_ff, pos_in, pos_cur;
   logic [7:0]             payload_ff [NUM_PAYLOAD];
   pins_type               pins_ff, pins_in;
   logic [NUM_SLOTS-1:0]   pend_ff, pend_in;
   slot_type               slot_ff [NUM_SLOTS];
   slot_type               cand [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   cand_valid;
   pins_type               cand_pins;
   logic                   req_acc, frame_done;
   logic [NUM_SLOTS-1:0]   sel, rest;
   slot_type               chosen;
   logic                   move;
   logic                   rsp_valid_ff, rsp_valid_in;
   slot_type               rsp_slot_ff;
   logic                   rsp_last_ff;
   logic [2:0]             wr_idx;

   // position past the end counts as header hunting
   assign pos_cur   = (pos_ff > POS_TRAILER) ? POS_HEADER : pos_ff;
   assign req_stall = (pos_cur == POS_TRAILER) && (|pend_ff);
   assign req_acc   = req_valid && !req_stall;
   assign frame_done = req_acc && (pos_cur == POS_TRAILER) && (req_rx_byte == SYNC_BYTE);
   assign wr_idx    = 3'(pos_cur - POS_PAYLOAD);

   // frame position
   always_comb begin
      pos_in = pos_cur;
      if (req_acc) begin
         if (pos_cur == POS_HEADER) begin
            pos_in = (req_rx_byte == HDR_BYTE) ? POS_SYNC : POS_HEADER;
         end else if (pos_cur == POS_SYNC) begin
            pos_in = (req_rx_byte == SYNC_BYTE) ? POS_PAYLOAD : POS_HEADER;
         end else if (pos_cur == POS_TRAILER) begin
            pos_in = POS_HEADER;
         end else begin
            pos_in = pos_cur + 4'd1;
         end
      end
   end

   // settings applied in field order, pins snapshot per slot
   always_comb begin
      cand_pins  = pins_ff;
      cand_valid = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         cand[i] = '0;
      end
      // heading, motion, gnss
      for (int k = 0; k < 3; k++) begin
         if (payload_ff[k] == FIELD_LOW || payload_ff[k] == FIELD_HIGH) begin
            cand_pins[PIN_HEAD + k] = payload_ff[k][0];
            cand_valid[k]           = 1'b1;
            cand[k].code            = status_code_type'(2 * k) | {3'b000, payload_ff[k][0]};
            cand[k].pins            = cand_pins;
         end
      end
      // pps
      if (payload_ff[PL_PPS] == FIELD_LOW || payload_ff[PL_PPS] == FIELD_HIGH) begin
         cand_pins[PIN_PULSE]   = payload_ff[PL_PPS][0];
         cand_valid[SLOT_PPS]   = 1'b1;
         cand[SLOT_PPS].code    = payload_ff[PL_PPS][0] ? ST_PPS_TTL : ST_PPS_422;
         cand[SLOT_PPS].pins    = cand_pins;
      end
      // svp / sync mode
      if (payload_ff[PL_MODE] == MODE_OFF) begin
         cand_pins[PIN_TTL]    = 1'b1;
         cand_valid[SLOT_MODE] = 1'b1;
         cand[SLOT_MODE].code  = ST_MODE_OFF;
         cand[SLOT_MODE].pins  = cand_pins;
      end else if (payload_ff[PL_MODE] == MODE_SYNC) begin
         cand_pins[PIN_TTL]    = 1'b0;
         cand_valid[SLOT_MODE] = 1'b1;
         cand[SLOT_MODE].code  = ST_MODE_SYNC;
         cand[SLOT_MODE].pins  = cand_pins;
      end else if (payload_ff[PL_MODE] == MODE_SVP) begin
         cand_pins[PIN_TTL]    = 1'b1;
         cand_valid[SLOT_MODE] = 1'b1;
         cand[SLOT_MODE].code  = ST_MODE_SVP;
         cand[SLOT_MODE].pins  = cand_pins;
      end
      // sub-mode: svp interface or sync direction
      if (payload_ff[PL_MODE] == MODE_SVP) begin
         if (payload_ff[PL_SVP] == FIELD_LOW) begin
            cand_pins[PIN_AUX232] = 1'b1;
            cand_valid[SLOT_SUB]  = 1'b1;
            cand[SLOT_SUB].code   = ST_SVP_422;
            cand[SLOT_SUB].pins   = cand_pins;
         end else if (payload_ff[PL_SVP] == FIELD_HIGH) begin
            cand_pins[PIN_AUX232] = 1'b0;
            cand_valid[SLOT_SUB]  = 1'b1;
            cand[SLOT_SUB].code   = ST_SVP_232;
            cand[SLOT_SUB].pins   = cand_pins;
         end
      end else if (payload_ff[PL_MODE] == MODE_SYNC) begin
         if (payload_ff[PL_SYNC] == FIELD_HIGH) begin
            cand_pins[PIN_AUXSD] = 1'b0;
            cand_pins[PIN_AUXRX] = 1'b1;
            cand[SLOT_SUB].code  = ST_SYNC_OUT;
         end else begin
            cand_pins[PIN_AUXSD] = 1'b1;
            cand_pins[PIN_AUXRX] = 1'b0;
            cand[SLOT_SUB].code  = ST_SYNC_IN;
         end
         cand_valid[SLOT_SUB] = 1'b1;
         cand[SLOT_SUB].pins  = cand_pins;
      end
   end

   // drain lowest pending slot into the output register
   assign sel  = pend_ff & (~pend_ff + 1'b1);
   assign rest = pend_ff & ~sel;
   assign move = (|pend_ff) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      chosen = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel[i]) begin
            chosen = chosen | slot_ff[i];
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (frame_done) begin
         pend_in = cand_valid;
      end else if (move) begin
         pend_in = rest;
      end
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = |pend_ff;
      end
      pins_in = frame_done ? cand_pins : pins_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HEADER;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pins_ff      <= PIN_RESET;
      end else begin
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         pins_ff      <= pins_in;
      end
   end

   // payload, slot and output data registers
   always_ff @(posedge clock) begin
      if (req_acc && pos_cur >= POS_PAYLOAD && pos_cur < POS_TRAILER) begin
         payload_ff[wr_idx] <= req_rx_byte;
      end
      if (frame_done) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= cand[i];
         end
      end
      if (move) begin
         rsp_slot_ff <= chosen;
         rsp_last_ff <= (rest == '0);
      end
   end

   // result ports
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status_code        = rsp_slot_ff.code;
   assign rsp_heading_select     = rsp_slot_ff.pins[0];
   assign rsp_motion_select      = rsp_slot_ff.pins[1];
   assign rsp_gnss_select        = rsp_slot_ff.pins[2];
   assign rsp_pulse_select       = rsp_slot_ff.pins[PIN_PULSE];
   assign rsp_aux_232_485_select = rsp_slot_ff.pins[PIN_AUX232];
   assign rsp_aux_receive_drive  = rsp_slot_ff.pins[PIN_AUXRX];
   assign rsp_aux_shutdown_drive = rsp_slot_ff.pins[PIN_AUXSD];
   assign rsp_ttl_path_select    = rsp_slot_ff.pins[PIN_TTL];
   assign rsp_last_status        = rsp_last_ff;

endmodule

>>> hdl/smfr_checker.sv
`include "serial_mode_frame_receiver_defines.svh"

module smfr_checker
   import smfr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_status_code,
   input logic       rsp_heading_select,
   input logic       rsp_aux_receive_drive,
   input logic       rsp_aux_shutdown_drive,
   input logic       rsp_last_status
);

   // a held result beat keeps its code and last flag
   `SMFR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status_code) && $stable(rsp_last_status), "stalled status beat changed")

   // output register is empty right after reset
   `SMFR_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "status beat right after reset")

   // status codes stay within the defined set
   `SMFR_ASSERT(a_code_range, clock, reset, rsp_valid |-> rsp_status_code <= ST_CODE_MAX, "status code out of range")

   // heading pin agrees with a heading code
   `SMFR_ASSERT(a_head_pin, clock, reset, rsp_valid && (rsp_status_code == ST_HEAD_232 || rsp_status_code == ST_HEAD_422) |-> rsp_heading_select == rsp_status_code[0], "heading pin disagrees with code")

   // sync output sets receive high and shutdown low
   `SMFR_ASSERT(a_sync_out_pins, clock, reset, rsp_valid && rsp_status_code == ST_SYNC_OUT |-> rsp_aux_receive_drive && !rsp_aux_shutdown_drive, "sync output pin levels wrong")

endmodule

bind serial_mode_frame_receiver smfr_checker u_smfr_checker (.*);
